// ----- sv/euler_to_quaternion_defines.svh -----
// Assertion macros for the Euler-to-quaternion block.
// Used by euler_to_quaternion.sv; expects clk and arst_n in scope.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// overlapping implication, disabled in reset
`define E2Q_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("e2q assertion failed");

// next-cycle implication, disabled in reset
`define E2Q_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("e2q assertion failed");

`endif

// ----- sv/e2q_pkg.sv -----
// Shared types and constants for the Euler-to-quaternion pipeline.
// No dependencies.
`timescale 1ns / 1ps

package e2q_pkg;

	localparam int OUT_WIDTH_DEF = 16;
	localparam int STAGES_DEF    = 16;

	localparam int ANG_W = 16;  // input angle width
	localparam int CW    = 32;  // CORDIC datapath width, Q30

	// half-angle reduction bounds, 1/256 degree units
	localparam logic signed [16:0] HALF_RIGHT = 17'sd23040;
	localparam logic signed [16:0] HALF_TURN  = 17'sd46080;

	// radians per unit, Q46
	localparam logic signed [33:0] RAD_K = 34'sd4797524517;

	// inverse CORDIC gain, Q30
	localparam logic signed [CW-1:0] GAIN_INV = 32'sd652032874;

	localparam logic signed [CW-1:0] ATAN_Q30 [32] = '{
		32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
		32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
		32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
		32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
		32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
		32'sd1024,      32'sd512,       32'sd256,       32'sd128,
		32'sd64,        32'sd32,        32'sd16,        32'sd8,
		32'sd4,         32'sd2,         32'sd1,         32'sd0
	};

	// one rotator word: vector, residual angle, sign fix for the reduction
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} rot_t;

endpackage

// ----- sv/e2q_cordic_cell.sv -----
// One CORDIC rotation cell: a single micro-rotation, registered.
// Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_cordic_cell
	import e2q_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic clk,
	input  rot_t d,
	output rot_t q
);

	localparam logic signed [CW-1:0] ANG = ATAN_Q30[IDX % 32];

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	rot_t                 nxt;

	always_comb begin
		xs = d.x >>> (IDX % 64);
		ys = d.y >>> (IDX % 64);
		nxt.flip = d.flip;
		if (!d.z[CW-1]) begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - ANG;
		end else begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + ANG;
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end

endmodule

// ----- sv/e2q_angle_prep.sv -----
// Angle front end: halve-angle range fold and degree-to-radian scaling.
// Feeds the first CORDIC cell. Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_angle_prep
	import e2q_pkg::*;
(
	input  logic                    clk,
	input  logic signed [ANG_W-1:0] angle,
	output rot_t                    rot_s1
);

	logic signed [16:0] h_ext;
	logic signed [16:0] h_red;
	logic               flip;
	logic signed [49:0] prod;
	logic signed [49:0] prod_rnd;
	rot_t               nxt;

	always_comb begin
		h_ext = 17'(angle);
		flip  = 1'b0;
		h_red = h_ext;
		if (h_ext > HALF_RIGHT) begin
			h_red = h_ext - HALF_TURN;
			flip  = 1'b1;
		end else if (h_ext < -HALF_RIGHT) begin
			h_red = h_ext + HALF_TURN;
			flip  = 1'b1;
		end
		// folded value always fits 16 bits
		prod     = 50'($signed(h_red[15:0])) * 50'(RAD_K);
		prod_rnd = prod + (50'sd1 <<< 15);
		nxt.x    = GAIN_INV;
		nxt.y    = '0;
		nxt.z    = prod_rnd[47:16];
		nxt.flip = flip;
	end

	always_ff @(posedge clk) begin
		rot_s1 <= nxt;
	end

endmodule

// ----- sv/e2q_combine.sv -----
// Quaternion assembly: sign fix, pair products, final products, round and saturate.
// Four register stages. Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_combine
	import e2q_pkg::*;
#(
	parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
	input  logic                        clk,
	input  rot_t                        yaw_rot,
	input  rot_t                        pitch_rot,
	input  rot_t                        roll_rot,
	output logic signed [OUT_WIDTH-1:0] quat_x,
	output logic signed [OUT_WIDTH-1:0] quat_y,
	output logic signed [OUT_WIDTH-1:0] quat_z,
	output logic signed [OUT_WIDTH-1:0] quat_w
);

	localparam int SH = 61 - OUT_WIDTH;
	localparam logic signed [64:0] RND  = 65'sd1 <<< (SH - 1);
	localparam logic signed [64:0] MAXV = (65'sd1 <<< (OUT_WIDTH - 1)) - 65'sd1;
	localparam logic signed [64:0] MINV = -MAXV - 65'sd1;
	localparam logic signed [63:0] HALF_Q30 = 64'sd1 <<< 29;

	function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [64:0] s);
		logic signed [64:0] v;
		v = (s + RND) >>> SH;
		if (v > MAXV)
			v = MAXV;
		else if (v < MINV)
			v = MINV;
		return v[OUT_WIDTH-1:0];
	endfunction

	function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + HALF_Q30;
		return p[61:30];
	endfunction

	// stage 1: undo the range fold
	logic signed [CW-1:0] cy_s1, sy_s1, cp_s1, sp_s1, cr_s1, sr_s1;

	always_ff @(posedge clk) begin
		cy_s1 <= yaw_rot.flip   ? -yaw_rot.x   : yaw_rot.x;
		sy_s1 <= yaw_rot.flip   ? -yaw_rot.y   : yaw_rot.y;
		cp_s1 <= pitch_rot.flip ? -pitch_rot.x : pitch_rot.x;
		sp_s1 <= pitch_rot.flip ? -pitch_rot.y : pitch_rot.y;
		cr_s1 <= roll_rot.flip  ? -roll_rot.x  : roll_rot.x;
		sr_s1 <= roll_rot.flip  ? -roll_rot.y  : roll_rot.y;
	end

	// stage 2: pitch-yaw pair products, Q30
	logic signed [CW-1:0] cpcy_s2, spsy_s2, spcy_s2, cpsy_s2, cr_s2, sr_s2;

	always_ff @(posedge clk) begin
		cpcy_s2 <= mul_q30(cp_s1, cy_s1);
		spsy_s2 <= mul_q30(sp_s1, sy_s1);
		spcy_s2 <= mul_q30(sp_s1, cy_s1);
		cpsy_s2 <= mul_q30(cp_s1, sy_s1);
		cr_s2   <= cr_s1;
		sr_s2   <= sr_s1;
	end

	// stage 3: roll products, Q60
	logic signed [63:0] p_sr_cpcy_s3, p_cr_spsy_s3, p_cr_spcy_s3, p_sr_cpsy_s3;
	logic signed [63:0] p_cr_cpsy_s3, p_sr_spcy_s3, p_cr_cpcy_s3, p_sr_spsy_s3;

	always_ff @(posedge clk) begin
		p_sr_cpcy_s3 <= 64'(sr_s2) * 64'(cpcy_s2);
		p_cr_spsy_s3 <= 64'(cr_s2) * 64'(spsy_s2);
		p_cr_spcy_s3 <= 64'(cr_s2) * 64'(spcy_s2);
		p_sr_cpsy_s3 <= 64'(sr_s2) * 64'(cpsy_s2);
		p_cr_cpsy_s3 <= 64'(cr_s2) * 64'(cpsy_s2);
		p_sr_spcy_s3 <= 64'(sr_s2) * 64'(spcy_s2);
		p_cr_cpcy_s3 <= 64'(cr_s2) * 64'(cpcy_s2);
		p_sr_spsy_s3 <= 64'(sr_s2) * 64'(spsy_s2);
	end

	// stage 4: sums, rounding, saturation
	always_ff @(posedge clk) begin
		quat_x <= to_out(65'(p_sr_cpcy_s3) - 65'(p_cr_spsy_s3));
		quat_y <= to_out(65'(p_cr_spcy_s3) + 65'(p_sr_cpsy_s3));
		quat_z <= to_out(65'(p_cr_cpsy_s3) - 65'(p_sr_spcy_s3));
		quat_w <= to_out(65'(p_cr_cpcy_s3) + 65'(p_sr_spsy_s3));
	end

endmodule

// ----- sv/euler_to_quaternion.sv -----
// Throughput: one word per cycle; one prep stage, a row of SINCOS_STAGES CORDIC
// cells per angle and four combine stages, all fully pipelined.
// busy is never asserted; done pulses for one cycle with each result word.
// Reset clears only the valid chain; payload registers are not reset.
`timescale 1ns / 1ps
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion
	import e2q_pkg::*;
#(
	parameter int OUT_WIDTH     = OUT_WIDTH_DEF,
	parameter int SINCOS_STAGES = STAGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [ANG_W-1:0]     yaw_angle,
	input  logic signed [ANG_W-1:0]     pitch_angle,
	input  logic signed [ANG_W-1:0]     roll_angle,
	output logic                        done,
	output logic signed [OUT_WIDTH-1:0] quat_x,
	output logic signed [OUT_WIDTH-1:0] quat_y,
	output logic signed [OUT_WIDTH-1:0] quat_z,
	output logic signed [OUT_WIDTH-1:0] quat_w
);

	localparam int LAT = SINCOS_STAGES + 5;

	logic                    accept;
	logic [LAT-1:0]          vld_q;
	logic signed [ANG_W-1:0] angles [3];
	rot_t                    chain [3][SINCOS_STAGES+1];

	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign done   = vld_q[LAT-1];

	assign angles[0] = yaw_angle;
	assign angles[1] = pitch_angle;
	assign angles[2] = roll_angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	for (genvar ln = 0; ln < 3; ln++) begin : g_lane
		e2q_angle_prep u_prep (
			.clk    (clk),
			.angle  (angles[ln]),
			.rot_s1 (chain[ln][0])
		);
		for (genvar st = 0; st < SINCOS_STAGES; st++) begin : g_cell
			e2q_cordic_cell #(
				.IDX (st)
			) u_cell (
				.clk (clk),
				.d   (chain[ln][st]),
				.q   (chain[ln][st+1])
			);
		end
	end

	e2q_combine #(
		.OUT_WIDTH (OUT_WIDTH)
	) u_combine (
		.clk       (clk),
		.yaw_rot   (chain[0][SINCOS_STAGES]),
		.pitch_rot (chain[1][SINCOS_STAGES]),
		.roll_rot  (chain[2][SINCOS_STAGES]),
		.quat_x    (quat_x),
		.quat_y    (quat_y),
		.quat_z    (quat_z),
		.quat_w    (quat_w)
	);

	// every accepted word comes out on done once it has passed the whole pipeline, and nothing else does
	`E2Q_ASSERT_IMP(a_word_out, accept, ##LAT done)
	`E2Q_ASSERT_IMP(a_no_stray, done, $past(accept, LAT))
	// zero rotation gives a positive scalar part
	`E2Q_ASSERT_IMP(a_zero_rot, accept && yaw_angle == '0 && pitch_angle == '0 && roll_angle == '0, ##LAT (done && !quat_w[OUT_WIDTH-1]))
	// pulse, not a level, for an isolated word
	`E2Q_ASSERT_NXT(a_pulse, done && !$past(accept, LAT - 1), !done)

endmodule

// ----- test/tb.sv -----
// Self-checking bench for euler_to_quaternion: streams yaw/pitch/roll words, predicts
// each quaternion in 64-bit integer math and compares every done word field by field.
// Depends on e2q_pkg (angle width) and the euler_to_quaternion RTL.
`timescale 1ns / 1ps

module tb;
	import e2q_pkg::*;

	localparam int QW     = 16;
	localparam int STAGES = 16;
	localparam int N_RAND = 800;
	localparam int LIMIT  = 100000;

	// half-angle fold points, 1/256 degree units
	localparam longint RIGHT_ANGLE = 64'sd23040;
	localparam longint FULL_SPAN   = 64'sd46080;
	localparam longint RAD_Q46     = 64'sd4797524517;
	localparam longint KINV_Q30    = 64'sd652032874;

	typedef struct {
		logic signed [ANG_W-1:0] yaw;
		logic signed [ANG_W-1:0] pitch;
		logic signed [ANG_W-1:0] roll;
		int unsigned             gap_pct;
	} angle_word_t;

	typedef struct packed {
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
		logic signed [QW-1:0] w;
	} quat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [ANG_W-1:0] yaw_angle = '0;
	logic signed [ANG_W-1:0] pitch_angle = '0;
	logic signed [ANG_W-1:0] roll_angle = '0;
	logic busy;
	logic done;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;
	logic signed [QW-1:0] quat_w;

	angle_word_t angle_q[$];
	quat_t       quat_q[$];
	longint      atan_tbl [32] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
		131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
		128, 64, 32, 16, 8, 4, 2, 1, 0
	};

	int n_total = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_wide = 0;
	int n_sat = 0;
	int n_err = 0;
	int cycle_cnt = 0;

	euler_to_quaternion #(
		.OUT_WIDTH(QW),
		.SINCOS_STAGES(STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.yaw_angle(yaw_angle),
		.pitch_angle(pitch_angle),
		.roll_angle(roll_angle),
		.done(done),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z),
		.quat_w(quat_w)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cos/sin of the half angle, Q30, folded into +/-90 deg before the rotator
	task automatic half_sincos(input logic signed [ANG_W-1:0] ang, output longint c,
			output longint s);
		longint h;
		longint x;
		longint y;
		longint z;
		longint nx;
		bit     fold;
		h = 64'(ang);
		fold = 1'b0;
		if (h > RIGHT_ANGLE) begin
			h = h - FULL_SPAN;
			fold = 1'b1;
		end else if (h < -RIGHT_ANGLE) begin
			h = h + FULL_SPAN;
			fold = 1'b1;
		end
		z = (h * RAD_Q46 + 64'sd32768) >>> 16;
		x = KINV_Q30;
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - atan_tbl[i % 32];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + atan_tbl[i % 32];
			end
			x = nx;
		end
		if (fold) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endtask

	function automatic longint mul_q30(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic signed [QW-1:0] round_sat(longint q60);
		longint v;
		longint maxv;
		maxv = (64'sd1 <<< (QW - 1)) - 1;
		v = (q60 + (64'sd1 <<< (60 - QW))) >>> (61 - QW);
		if (v > maxv)
			v = maxv;
		if (v < -maxv - 1)
			v = -maxv - 1;
		return v[QW-1:0];
	endfunction

	task automatic zyx_quat(input angle_word_t a, output quat_t q);
		longint cy, sy, cp, sp, cr, sr;
		longint cpcy, spsy, spcy, cpsy;
		half_sincos(a.yaw, cy, sy);
		half_sincos(a.pitch, cp, sp);
		half_sincos(a.roll, cr, sr);
		cpcy = mul_q30(cp, cy);
		spsy = mul_q30(sp, sy);
		spcy = mul_q30(sp, cy);
		cpsy = mul_q30(cp, sy);
		q.x = round_sat(sr * cpcy - cr * spsy);
		q.y = round_sat(cr * spcy + sr * cpsy);
		q.z = round_sat(cr * cpsy - sr * spcy);
		q.w = round_sat(cr * cpcy + sr * spsy);
	endtask

	task automatic check_comp(input string name, input logic signed [QW-1:0] want,
			input logic signed [QW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
			n_err++;
		end
		if (got == {1'b0, {(QW-1){1'b1}}} || got == {1'b1, {(QW-1){1'b0}}})
			n_sat++;
	endtask

	function automatic logic signed [ANG_W-1:0] rand_angle();
		logic signed [ANG_W-1:0] a;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: a = 16'($urandom_range(0, 46080) - 23040);
			6, 7: a = 16'($urandom);
			// around the fold points and the ends of the 16-bit range
			8: begin
				case ($urandom_range(0, 3))
					0: a = 16'(23040 + $urandom_range(0, 4) - 2);
					1: a = 16'(-23040 + $urandom_range(0, 4) - 2);
					2: a = 16'(16'sh7fff - $urandom_range(0, 3));
					default: a = 16'(16'sh8000 + $urandom_range(0, 3));
				endcase
			end
			default: a = 16'($urandom_range(0, 255) - 128);
		endcase
		return a;
	endfunction

	task automatic queue_word(input logic signed [ANG_W-1:0] y,
			input logic signed [ANG_W-1:0] p, input logic signed [ANG_W-1:0] r,
			input int unsigned gap);
		angle_word_t a;
		a.yaw = y;
		a.pitch = p;
		a.roll = r;
		a.gap_pct = gap;
		angle_q.push_back(a);
		n_total++;
	endtask

	// driver: a word goes when start is high and busy low at the edge
	always @(posedge clk) begin : drive
		angle_word_t a;
		quat_t       q;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				a.yaw = yaw_angle;
				a.pitch = pitch_angle;
				a.roll = roll_angle;
				zyx_quat(a, q);
				quat_q.push_back(q);
				n_accepted++;
				if (yaw_angle > 23040 || yaw_angle < -23040 || pitch_angle > 23040 ||
						pitch_angle < -23040 || roll_angle > 23040 || roll_angle < -23040)
					n_wide++;
			end
			if (start && busy) begin
				// hold the word until taken
			end else if (angle_q.size() != 0 &&
					$urandom_range(0, 99) >= angle_q[0].gap_pct) begin
				a = angle_q.pop_front();
				start <= 1'b1;
				yaw_angle <= a.yaw;
				pitch_angle <= a.pitch;
				roll_angle <= a.roll;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		quat_t want;
		if (arst_n && done) begin
			n_results++;
			if (quat_q.size() == 0) begin
				$display("%0t: unexpected word, expected none got x=%0d y=%0d z=%0d w=%0d",
					$time, quat_x, quat_y, quat_z, quat_w);
				n_err++;
			end else begin
				want = quat_q.pop_front();
				check_comp("quat_x", want.x, quat_x);
				check_comp("quat_y", want.y, quat_y);
				check_comp("quat_z", want.z, quat_z);
				check_comp("quat_w", want.w, quat_w);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("%0t: timeout, %0d words still expected", $time, quat_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int unsigned gap;
		// directed: fold points, 16-bit ends, unit and saturating components
		queue_word(0, 0, 0, 0);
		queue_word(23040, 0, 0, 0);
		queue_word(-23040, 0, 0, 0);
		queue_word(0, 23040, 0, 0);
		queue_word(0, -23040, 0, 0);
		queue_word(0, 0, 23040, 0);
		queue_word(0, 0, -23040, 0);
		queue_word(32767, 32767, 32767, 0);
		queue_word(-32768, -32768, -32768, 0);
		queue_word(23041, -23041, 0, 0);
		queue_word(-23041, 23041, 32767, 0);
		queue_word(23039, -23039, 23041, 0);
		queue_word(11520, 11520, 11520, 0);
		queue_word(-11520, 5760, -5760, 0);
		queue_word(1, -1, 1, 0);
		queue_word(-1, 1, -1, 0);
		queue_word(23040, 23040, 23040, 0);
		queue_word(-23040, -23040, -23040, 0);
		queue_word(0, 0, -32768, 0);
		queue_word(32767, -32768, 0, 0);
		queue_word(16384, -16384, 8192, 0);
		queue_word(-21845, 21845, -1, 0);
		for (int i = 0; i < N_RAND; i++) begin
			case (i / (N_RAND / 4))
				1: gap = 56;
				2: gap = 26;
				default: gap = 0;
			endcase
			queue_word(rand_angle(), rand_angle(), rand_angle(), gap);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total)
			@(negedge clk);
		while (quat_q.size() != 0)
			@(negedge clk);
		// pipeline is 21 deep; catch any stray done
		repeat (40) @(negedge clk);

		$display("%0d angle words converted, %0d with an angle past +/-180 deg,", n_accepted,
			n_wide);
		$display("%0d result words checked, %0d components at full scale", n_results, n_sat);
		if (n_err == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
